@@ src/sha256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 hasher.
package sha256_pkg;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COMP = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Requests from the controller to the schedule memory unit
  typedef struct packed {
    logic        wr_en;    // byte packer writes a finished word
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic        issue;    // issue schedule reads for index idx
    logic [5:0]  idx;
  } sched_req_t;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [6:0] CNT_RND_LO = 7'd2;
  localparam logic [6:0] CNT_RND_HI = 7'd65;
  localparam logic [6:0] CNT_FOLD   = 7'd66;
  localparam logic [3:0] LEN_BYTES  = 4'd8;
  localparam logic [2:0] WORD_LAST  = 3'd7;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message schedule sigma functions
  function automatic logic [31:0] sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  // Compression Sigma, choose and majority functions
  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

@@ src/sha256_if.sv @@
// Valid/ready channel interfaces for message bytes and digest words.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source(output valid, data_byte, byte_present, message_end, input ready);
  modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source(output valid, digest_word, digest_last, input ready);
  modport sink(input valid, digest_word, digest_last, output ready);
endinterface

@@ src/sha256_sched.sv @@
// Schedule memory: 16-word block buffer with read pipeline and W[t] expansion.
module sha256_sched (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha256_pkg::sched_req_t sched_req,
  output logic [31:0]            kw
);

  logic [31:0] mem [16];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;
  logic        s_vld_r;
  logic [5:0]  s_idx_r;
  logic [31:0] x_r;      // W[t-16] for the word being expanded
  logic [31:0] wq1_r;    // W[t-1]
  logic [31:0] wq2_r;    // W[t-2]
  logic [31:0] kw_r;
  logic [3:0]  addr_a;
  logic [3:0]  addr_b;
  logic [31:0] w_new;
  logic        late_word;
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;

  // Read addresses: W[t] for the first 16 words, then W[t-15] and W[t-7]
  always_comb begin
    if (sched_req.idx[5:4] == 2'b00) begin
      addr_a = sched_req.idx[3:0];
    end else begin
      addr_a = sched_req.idx[3:0] + 4'd1;
    end
    addr_b = sched_req.idx[3:0] + 4'd9;
  end

  // Expansion of the schedule word in the stage after the read
  assign late_word = (s_idx_r[5:4] != 2'b00);

  always_comb begin
    if (late_word) begin
      w_new = x_r + sha256_pkg::sig0(rd_a_r) + rd_b_r + sha256_pkg::sig1(wq2_r);
    end else begin
      w_new = rd_a_r;
    end
  end

  // Single write port: byte packer while idle or padding, expanded words during rounds
  always_comb begin
    mem_we    = sched_req.wr_en || (s_vld_r && late_word);
    mem_waddr = sched_req.wr_en ? sched_req.wr_addr : s_idx_r[3:0];
    mem_wdata = sched_req.wr_en ? sched_req.wr_data : w_new;
  end

  // Memory array, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (sched_req.issue) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
    end
  end

  // Read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      s_idx_r <= '0;
    end else begin
      s_vld_r <= sched_req.issue;
      s_idx_r <= sched_req.idx;
    end
  end

  // Expansion history and round constant sum
  always_ff @(posedge clk) begin
    if (s_vld_r) begin
      wq1_r <= w_new;
      wq2_r <= wq1_r;
      kw_r  <= sha256_pkg::ROUND_K[s_idx_r] + w_new;
      if (late_word || s_idx_r == 6'd0) begin
        x_r <= rd_a_r;
      end
    end
  end

  assign kw = kw_r;

endmodule

@@ src/sha256_hash_top.sv @@
// SHA-256 hasher top level: byte packing, padding, compression rounds, digest output.
//
//  Channel   Dir  Transaction
//  in_chan   in   one message byte and/or end-of-message flag
//  out_chan  out  one 32-bit digest word, eight per message, last flagged
//
//  Bytes are taken one per cycle while idle; each full 64-byte block is then compressed
//  (load, 64 rounds fed by the schedule memory's registered read path, then fold).
//  Padding inserts 9 to 72 bytes before the digest, at one per cycle while not compressing.
//  in_chan.ready is low during compression, padding and digest output; a stalled
//  out_chan holds the current word. Synchronous reset loads the initial hash value.
module sha256_hash_top (
  input  logic                 clk,
  input  logic                 rst_n,
  sha256_in_if.sink            in_chan,
  sha256_out_if.source         out_chan
);

  sha256_pkg::state_t     state_r, state_nxt;
  logic [6:0]             cnt_r, cnt_nxt;
  logic [5:0]             fill_r, fill_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [63:0]            bitlen_r, bitlen_nxt;
  logic                   mark_r, mark_nxt;
  logic [3:0]             len_cnt_r, len_cnt_nxt;
  logic                   pad_act_r, pad_act_nxt;
  logic [2:0]             out_idx_r, out_idx_nxt;
  logic [31:0]            chain_r [8];
  logic [31:0]            chain_nxt [8];
  logic [31:0]            wv_r [8];
  logic [31:0]            wv_nxt [8];
  logic                   in_acc;
  logic                   put_en;
  logic [7:0]             put_byte;
  logic [7:0]             pad_byte;
  logic                   round_en;
  logic [31:0]            kw;
  logic [31:0]            t1;
  logic [31:0]            t2;
  sha256_pkg::sched_req_t sched_req;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == sha256_pkg::ST_IDLE);

  // Padding byte source: marker, zeros to the length offset, then length MSB first
  always_comb begin
    if (!mark_r) begin
      pad_byte = sha256_pkg::PAD_MARK;
    end else if (len_cnt_r == 4'd0 && fill_r != sha256_pkg::LEN_OFFSET) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bitlen_r[{~len_cnt_r[2:0], 3'b000} +: 8];
    end
  end

  // Byte packer input
  always_comb begin
    put_en   = 1'b0;
    put_byte = pad_byte;
    if (state_r == sha256_pkg::ST_IDLE) begin
      put_en   = in_acc && in_chan.byte_present;
      put_byte = in_chan.data_byte;
    end else if (state_r == sha256_pkg::ST_PAD) begin
      put_en   = 1'b1;
    end
  end

  // Schedule memory requests
  assign round_en = (state_r == sha256_pkg::ST_COMP) && (cnt_r >= sha256_pkg::CNT_RND_LO)
                    && (cnt_r <= sha256_pkg::CNT_RND_HI);

  always_comb begin
    sched_req.wr_en   = put_en && (fill_r[1:0] == 2'b11);
    sched_req.wr_addr = fill_r[5:2];
    sched_req.wr_data = {word_r[23:0], put_byte};
    sched_req.issue   = (state_r == sha256_pkg::ST_COMP) && !cnt_r[6];
    sched_req.idx     = cnt_r[5:0];
  end

  sha256_sched u_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .sched_req (sched_req),
    .kw        (kw)
  );

  // Round arithmetic
  assign t1 = wv_r[7] + sha256_pkg::bsig1(wv_r[4])
              + sha256_pkg::ch(wv_r[4], wv_r[5], wv_r[6]) + kw;
  assign t2 = sha256_pkg::bsig0(wv_r[0]) + sha256_pkg::maj(wv_r[0], wv_r[1], wv_r[2]);

  // Controller next state
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    fill_nxt    = fill_r;
    word_nxt    = word_r;
    bitlen_nxt  = bitlen_r;
    mark_nxt    = mark_r;
    len_cnt_nxt = len_cnt_r;
    pad_act_nxt = pad_act_r;
    out_idx_nxt = out_idx_r;
    for (int i = 0; i < 8; i++) begin
      chain_nxt[i] = chain_r[i];
      wv_nxt[i]    = wv_r[i];
    end

    if (put_en) begin
      word_nxt = {word_r[23:0], put_byte};
      fill_nxt = fill_r + 6'd1;
    end

    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.byte_present) begin
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_chan.message_end) begin
            pad_act_nxt = 1'b1;
          end
          if (in_chan.byte_present && fill_r == sha256_pkg::FILL_LAST) begin
            state_nxt = sha256_pkg::ST_COMP;
            cnt_nxt   = '0;
          end else if (in_chan.message_end) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (!mark_r) begin
          mark_nxt = 1'b1;
        end else if (!(len_cnt_r == 4'd0 && fill_r != sha256_pkg::LEN_OFFSET)) begin
          len_cnt_nxt = len_cnt_r + 4'd1;
        end
        if (fill_r == sha256_pkg::FILL_LAST) begin
          state_nxt = sha256_pkg::ST_COMP;
          cnt_nxt   = '0;
        end
      end
      sha256_pkg::ST_COMP: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd0) begin
          for (int i = 0; i < 8; i++) begin
            wv_nxt[i] = chain_r[i];
          end
        end
        if (round_en) begin
          wv_nxt[7] = wv_r[6];
          wv_nxt[6] = wv_r[5];
          wv_nxt[5] = wv_r[4];
          wv_nxt[4] = wv_r[3] + t1;
          wv_nxt[3] = wv_r[2];
          wv_nxt[2] = wv_r[1];
          wv_nxt[1] = wv_r[0];
          wv_nxt[0] = t1 + t2;
        end
        // fold the working variables into the chaining value
        if (cnt_r == sha256_pkg::CNT_FOLD) begin
          for (int i = 0; i < 8; i++) begin
            chain_nxt[i] = chain_r[i] + wv_r[i];
          end
          if (!pad_act_r) begin
            state_nxt = sha256_pkg::ST_IDLE;
          end else if (len_cnt_r == sha256_pkg::LEN_BYTES) begin
            state_nxt   = sha256_pkg::ST_OUT;
            out_idx_nxt = '0;
          end else begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_OUT: begin
        if (out_chan.ready) begin
          out_idx_nxt = out_idx_r + 3'd1;
          if (out_idx_r == sha256_pkg::WORD_LAST) begin
            state_nxt   = sha256_pkg::ST_IDLE;
            bitlen_nxt  = '0;
            mark_nxt    = 1'b0;
            len_cnt_nxt = '0;
            pad_act_nxt = 1'b0;
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = sha256_pkg::INIT_HASH[i];
            end
          end
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // Control, chaining and working-variable registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha256_pkg::ST_IDLE;
      cnt_r     <= '0;
      fill_r    <= '0;
      bitlen_r  <= '0;
      mark_r    <= 1'b0;
      len_cnt_r <= '0;
      pad_act_r <= 1'b0;
      out_idx_r <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha256_pkg::INIT_HASH[i];
        wv_r[i]    <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      fill_r    <= fill_nxt;
      bitlen_r  <= bitlen_nxt;
      mark_r    <= mark_nxt;
      len_cnt_r <= len_cnt_nxt;
      pad_act_r <= pad_act_nxt;
      out_idx_r <= out_idx_nxt;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= chain_nxt[i];
        wv_r[i]    <= wv_nxt[i];
      end
    end
  end

  // Partial word being packed
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Digest output
  assign out_chan.valid       = (state_r == sha256_pkg::ST_OUT);
  assign out_chan.digest_word = chain_r[out_idx_r];
  assign out_chan.digest_last = (out_idx_r == sha256_pkg::WORD_LAST);

endmodule
